// ----- hw/rtl/cpi_pkg.sv -----
// ============================================================================
// cpi_pkg
// Shared types, constants and helpers of the colour patch indexer.
// ============================================================================
`default_nettype none

package cpi_pkg;

    // Sizing
    localparam int CHANNELS    = 4;
    localparam int TABLE_DEPTH = 256;
    localparam int MAX_PIXELS  = 1048576;

    localparam int CHAN_W    = 8;
    localparam int PIXEL_W   = 32;
    localparam int COUNT_W   = 21;
    localparam int POS_W     = 20;
    localparam int CLASS_IDX_W = 8;

    localparam int TBL_IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int USED_W    = $clog2(TABLE_DEPTH + 1);
    localparam int POS_CNT_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Result word layout
    localparam int OUT_FIELDS_W = POS_W + 1 + CLASS_IDX_W + 1 + COUNT_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN_MASK  = 1'd1;

    localparam logic [CHANNELS-1:0] MASK_RESET = '1;

    // Input word kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Search engine states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } cpi_state_t;

    // One table entry: running size over stored colour
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [PIXEL_W-1:0] color;
    } cpi_entry_t;

    // Request from the stream front end to the table engine
    typedef struct packed {
        logic                start;
        logic                clear;
        logic                is_bg;
        logic [PIXEL_W-1:0]  pixel;
        logic [CHANNELS-1:0] mask;
    } cpi_req_t;

    // Result handed back by the table engine
    typedef struct packed {
        logic                   done;
        logic                   is_bg;
        logic [CLASS_IDX_W-1:0] class_index;
        logic                   is_new;
        logic [COUNT_W-1:0]     size;
        logic                   full;
    } cpi_resp_t;

    // True when a and b agree on every enabled channel
    function automatic logic colors_agree(input logic [PIXEL_W-1:0]  a,
                                          input logic [PIXEL_W-1:0]  b,
                                          input logic [CHANNELS-1:0] mask);
        logic agree;
        agree = 1'b1;
        for (int c = 0; c < CHANNELS; c++) begin
            if (mask[c] && (a[c*CHAN_W +: CHAN_W] != b[c*CHAN_W +: CHAN_W])) begin
                agree = 1'b0;
            end
        end
        return agree;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cpi_table_engine.sv -----
// ============================================================================
// cpi_table_engine
// Colour class table: linear search over the stored colours, one entry per
// cycle, then a read-modify-write of the count or a new entry.
// ============================================================================
`default_nettype none

module cpi_table_engine (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cpi_pkg::cpi_req_t  req,
    input  wire logic               out_free,
    output cpi_pkg::cpi_resp_t      resp
);
    import cpi_pkg::*;

    cpi_state_t state_reg, state_next;

    logic [USED_W-1:0]    used_reg, used_next;
    logic [USED_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                 cmp_vld_reg;
    logic [TBL_IDX_W-1:0] cmp_idx_reg;
    logic [PIXEL_W-1:0]   pix_reg, pix_next;
    logic [CHANNELS-1:0]  mask_reg, mask_next;

    logic                 res_bg_reg, res_bg_next;
    logic [TBL_IDX_W-1:0] res_idx_reg, res_idx_next;
    logic                 res_new_reg, res_new_next;
    logic [COUNT_W-1:0]   res_size_reg, res_size_next;
    logic                 res_full_reg, res_full_next;

    // Class table and its registered read port
    cpi_entry_t           mem [TABLE_DEPTH];
    cpi_entry_t           rd_data_reg;

    logic                 rd_en;
    logic                 wr_en;
    logic [TBL_IDX_W-1:0] wr_addr;
    cpi_entry_t           wr_data;

    logic                 match;
    logic                 last_cmp;
    logic                 miss;
    logic                 alloc;
    logic                 has_room;
    logic [PIXEL_W-1:0]   alloc_pix;
    logic [COUNT_W-1:0]   cnt_inc;

    // Search pipeline: address issued one cycle, compared the next
    assign rd_en    = (state_reg == ST_SCAN) && (rd_idx_reg < used_reg);
    assign match    = cmp_vld_reg && colors_agree(pix_reg, rd_data_reg.color, mask_reg);
    assign last_cmp = (USED_W'(cmp_idx_reg) + USED_W'(1)) == used_reg;
    assign miss     = (state_reg == ST_SCAN) && cmp_vld_reg && !match && last_cmp;
    assign has_room = used_reg < USED_W'(TABLE_DEPTH);
    assign cnt_inc  = (rd_data_reg.count == COUNT_MAX) ? rd_data_reg.count
                                                        : rd_data_reg.count + COUNT_W'(1);

    // Empty table: no search, allocate straight away
    assign alloc     = miss || ((state_reg == ST_IDLE) && req.start && !req.is_bg
                                && (used_reg == '0));
    assign alloc_pix = (state_reg == ST_IDLE) ? req.pixel : pix_reg;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    if (req.is_bg || (used_reg == '0)) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if ((state_reg == ST_SCAN) && (match || miss)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and table write
    always_comb begin
        used_next     = used_reg;
        rd_idx_next   = rd_idx_reg;
        pix_next      = pix_reg;
        mask_next     = mask_reg;
        res_bg_next   = res_bg_reg;
        res_idx_next  = res_idx_reg;
        res_new_next  = res_new_reg;
        res_size_next = res_size_reg;
        res_full_next = res_full_reg;
        wr_en         = 1'b0;
        wr_addr       = cmp_idx_reg;
        wr_data       = '{count: cnt_inc, color: rd_data_reg.color};

        case (state_reg)
            ST_IDLE: begin
                rd_idx_next = '0;
                if (req.clear) begin
                    used_next = '0;
                end
                if (req.start) begin
                    pix_next      = req.pixel;
                    mask_next     = req.mask;
                    res_bg_next   = req.is_bg;
                    res_idx_next  = '0;
                    res_new_next  = 1'b0;
                    res_size_next = '0;
                    res_full_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    rd_idx_next = rd_idx_reg + USED_W'(1);
                end
                // first match: bump the count in place
                if (match) begin
                    wr_en         = 1'b1;
                    res_idx_next  = cmp_idx_reg;
                    res_size_next = cnt_inc;
                end
            end
            ST_DONE: begin
                rd_idx_next = rd_idx_reg;
            end
            default: begin
                rd_idx_next = '0;
            end
        endcase

        // New colour: take the next free entry, or flag a full table
        if (alloc) begin
            if (has_room) begin
                wr_en         = 1'b1;
                wr_addr       = used_reg[TBL_IDX_W-1:0];
                wr_data       = '{count: COUNT_W'(1), color: alloc_pix};
                used_next     = used_reg + USED_W'(1);
                res_idx_next  = used_reg[TBL_IDX_W-1:0];
                res_new_next  = 1'b1;
                res_size_next = COUNT_W'(1);
            end else begin
                res_full_next = 1'b1;
            end
        end
    end

    // Result towards the output register
    always_comb begin
        resp.done        = (state_reg == ST_DONE) && out_free;
        resp.is_bg       = res_bg_reg;
        resp.class_index = CLASS_IDX_W'(res_idx_reg);
        resp.is_new      = res_new_reg;
        resp.size        = res_size_reg;
        resp.full        = res_full_reg;
    end

    // Table memory
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx_reg[TBL_IDX_W-1:0]];
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            rd_idx_reg  <= '0;
            cmp_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= rd_en;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmp_idx_reg  <= rd_idx_reg[TBL_IDX_W-1:0];
        pix_reg      <= pix_next;
        mask_reg     <= mask_next;
        res_bg_reg   <= res_bg_next;
        res_idx_reg  <= res_idx_next;
        res_new_reg  <= res_new_next;
        res_size_reg <= res_size_next;
        res_full_reg <= res_full_next;
    end

    // Checks
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= USED_W'(TABLE_DEPTH))
        else $error("class count above table depth");

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (USED_W'(wr_addr) <= used_reg))
        else $error("table write beyond the used entries");

    a_new_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (resp.done && resp.is_new) |-> ((resp.size == COUNT_W'(1)) && !resp.full
                                        && !resp.is_bg))
        else $error("new class result inconsistent");

    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (resp.done && resp.full) |-> (used_reg == USED_W'(TABLE_DEPTH)))
        else $error("table full flagged with free entries");

    a_alloc_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (alloc && has_room && !req.clear) |=> (used_reg == $past(used_reg) + USED_W'(1)))
        else $error("allocation did not advance the class count");

endmodule

`default_nettype wire

// ----- hw/rtl/color_patch_indexer_core.sv -----
// ============================================================================
// color_patch_indexer_core
// Groups non-background pixels into classes of identical colour on the
// enabled channels; reports position, class, newness and running class size.
// ============================================================================
// Flow: a background pixel, or any pixel while the table is empty, goes from
// accept straight to the done state; any other pixel is first compared against
// the stored classes in order, then the result is registered into m_tdata.
// One word is in flight at a time: s_tready stays low until the result is in the
// output register, and the search reads one stored colour per cycle through the
// single table read port. Clear words give no result.
// Reset: clears the class count, position counter and handshake state; the
// table itself needs no clearing pass.
`default_nettype none

module color_patch_indexer_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [cpi_pkg::PIXEL_W-1:0]       s_tdata,  // [31:0] pixel_value
    input  wire logic                              s_tuser,  // [0] kind
    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [19:0] pixel_position, [20] is_background, [28:21] class_index,
    // [29] is_new_class, [50:30] class_size, [51] table_full, [55:52] zero
    output logic [cpi_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [cpi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [cpi_pkg::PIXEL_W-1:0]       cfg_wdata
);
    import cpi_pkg::*;

    logic [PIXEL_W-1:0]     bg_color_reg, bg_color_next;
    logic [CHANNELS-1:0]    chan_mask_reg, chan_mask_next;
    logic                   busy_reg, busy_next;
    logic [POS_CNT_W-1:0]   pos_reg, pos_next;
    logic [POS_CNT_W-1:0]   pos_hold_reg, pos_hold_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic      accept;
    logic      pixel_acc;
    logic      out_free;
    cpi_req_t  req;
    cpi_resp_t resp;

    // Handshakes
    assign s_tready  = !busy_reg;
    assign accept    = s_tvalid && s_tready;
    assign pixel_acc = accept && (s_tuser == KIND_PIXEL);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Request to the table engine; background test on the incoming word
    always_comb begin
        req.start = pixel_acc;
        req.clear = accept && (s_tuser == KIND_CLEAR);
        req.is_bg = colors_agree(s_tdata, bg_color_reg, chan_mask_reg);
        req.pixel = s_tdata;
        req.mask  = chan_mask_reg;
    end

    cpi_table_engine u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .out_free (out_free),
        .resp     (resp)
    );

    // Configuration writes
    always_comb begin
        bg_color_next  = bg_color_reg;
        chan_mask_next = chan_mask_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_BACKGROUND: bg_color_next  = cfg_wdata;
                REG_CHAN_MASK:  chan_mask_next = cfg_wdata[CHANNELS-1:0];
                default: begin
                    bg_color_next  = bg_color_reg;
                    chan_mask_next = chan_mask_reg;
                end
            endcase
        end
    end

    // Position counter, busy flag and output register
    always_comb begin
        pos_next      = pos_reg;
        pos_hold_next = pos_hold_reg;
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (req.clear) begin
            pos_next = '0;
        end
        if (pixel_acc) begin
            pos_hold_next = pos_reg;
            busy_next     = 1'b1;
            pos_next      = (pos_reg == POS_CNT_W'(MAX_PIXELS - 1)) ? '0
                                                                    : pos_reg + POS_CNT_W'(1);
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (resp.done) begin
            busy_next     = 1'b0;
            m_tvalid_next = 1'b1;
            m_tdata_next  = {OUT_PAD_W'(0), resp.full, resp.size, resp.is_new,
                             resp.class_index, resp.is_bg, POS_W'(pos_hold_reg)};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bg_color_reg  <= '0;
            chan_mask_reg <= MASK_RESET;
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            bg_color_reg  <= bg_color_next;
            chan_mask_reg <= chan_mask_next;
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_hold_reg <= pos_hold_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

`default_nettype wire

// ----- sim/color_patch_indexer_core_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// color_patch_indexer_core_tb
// Self-checking bench for the colour patch indexer. Pixel and clear words are
// streamed in through the input channel. A local copy of the class table
// predicts every result word. The results are checked in order, field by
// field. Background colour and channel mask are reprogrammed between phases,
// always with the core idle.
// ============================================================================

module color_patch_indexer_core_tb;

    localparam int SETTLE_CYCLES = 300;      // above the longest table search
    localparam int DRAIN_LIMIT   = 400000;
    localparam int LONG_HOLD     = 400;
    localparam int TOTAL_WORDS   = 1650;
    localparam int LAST_WORDS    = 150;
    localparam int TIMEOUT_NS    = 20_000_000;

    // one input word as queued for the driver
    typedef struct packed {
        logic        kind;
        logic [31:0] value;
    } pixel_word_t;

    // one decoded result word
    typedef struct packed {
        logic [19:0] position;
        logic        is_bg;
        logic [7:0]  class_idx;
        logic        is_new;
        logic [20:0] class_size;
        logic        table_full;
    } pixel_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [cpi_pkg::PIXEL_W-1:0]        s_tdata   = '0;  // [31:0] pixel_value
    logic                               s_tuser   = cpi_pkg::KIND_PIXEL;  // [0] kind
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    // [19:0] pixel_position, [20] is_background, [28:21] class_index,
    // [29] is_new_class, [50:30] class_size, [51] table_full
    logic [cpi_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic                               cfg_wr_en = 1'b0;
    logic [cpi_pkg::CFG_IDX_W-1:0]      cfg_index = cpi_pkg::REG_BACKGROUND;
    logic [cpi_pkg::PIXEL_W-1:0]        cfg_wdata = '0;

    color_patch_indexer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus and expectation stores
    pixel_word_t   words_to_send[$];
    pixel_result_t expected_results[$];
    int unsigned   words_queued = 0;
    int unsigned   results_seen = 0;
    int unsigned   mismatches   = 0;
    bit            idling_on    = 1'b1;
    logic          long_hold_req = 1'b0;

    // shadow of the core's registers and class table
    logic [31:0] bg_shadow   = '0;
    logic [3:0]  mask_shadow = cpi_pkg::MASK_RESET;
    logic [31:0] palette_color [cpi_pkg::TABLE_DEPTH];
    logic [20:0] palette_count [cpi_pkg::TABLE_DEPTH];
    int unsigned palette_used  = 0;
    int unsigned position_next = 0;

    // agreement on the enabled channels only
    function automatic bit chan_match(input logic [31:0] a, input logic [31:0] b);
        for (int c = 0; c < cpi_pkg::CHANNELS; c++) begin
            if (mask_shadow[c] && (a[8*c +: 8] != b[8*c +: 8])) return 1'b0;
        end
        return 1'b1;
    endfunction

    // advance the shadow table by one word; returns 1 when a result is due
    function automatic bit classify_word(input logic kind, input logic [31:0] pix,
                                         output pixel_result_t r);
        int unsigned j;
        r = '0;
        if (kind == cpi_pkg::KIND_CLEAR) begin
            palette_used  = 0;
            position_next = 0;
            return 1'b0;
        end
        r.position    = position_next[19:0];
        position_next = (position_next + 1 >= cpi_pkg::MAX_PIXELS) ? 0 : position_next + 1;
        if (chan_match(pix, bg_shadow)) begin
            r.is_bg = 1'b1;
        end else begin
            j = 0;
            while (j < palette_used && !chan_match(pix, palette_color[j])) j++;
            if (j < palette_used) begin
                if (palette_count[j] != cpi_pkg::COUNT_MAX) palette_count[j]++;
                r.class_idx  = j[7:0];
                r.class_size = palette_count[j];
            end else if (palette_used < cpi_pkg::TABLE_DEPTH) begin
                palette_color[j] = pix;
                palette_count[j] = 21'd1;
                palette_used     = j + 1;
                r.class_idx      = j[7:0];
                r.is_new         = 1'b1;
                r.class_size     = 21'd1;
            end else begin
                r.table_full = 1'b1;
            end
        end
        return 1'b1;
    endfunction

    // input driver: one word per handshake, random gaps while idling is on
    int unsigned send_gap = 0;
    always @(posedge aclk) begin : drive_proc
        pixel_word_t   w;
        pixel_result_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (classify_word(s_tuser, s_tdata, r)) expected_results.push_back(r);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    w = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= w.kind;
                    s_tdata  <= w.value;
                    if (idling_on && $urandom_range(0, 7) == 0)
                        send_gap <= $urandom_range(1, 6);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink: short random stalls, one long hold on request
    int unsigned stall_left = 0;
    always @(posedge aclk) begin : sink_proc
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (long_hold_req) begin
            m_tready   <= 1'b0;
            stall_left <= LONG_HOLD;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 5);
        end else begin
            m_tready   <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin : check_proc
        pixel_result_t got;
        pixel_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.position   = m_tdata[19:0];
            got.is_bg      = m_tdata[20];
            got.class_idx  = m_tdata[28:21];
            got.is_new     = m_tdata[29];
            got.class_size = m_tdata[50:30];
            got.table_full = m_tdata[51];
            if (expected_results.size() == 0) begin
                if (mismatches < 10)
                    $display("result %0d: word with nothing expected, tdata=%h",
                             results_seen, m_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    if (mismatches < 10) begin
                        $display(
                            "result %0d exp pos=%0d bg=%0b cls=%0d new=%0b size=%0d full=%0b",
                            results_seen, want.position, want.is_bg, want.class_idx,
                            want.is_new, want.class_size, want.table_full);
                        $display(
                            "result %0d got pos=%0d bg=%0b cls=%0d new=%0b size=%0d full=%0b",
                            results_seen, got.position, got.is_bg, got.class_idx,
                            got.is_new, got.class_size, got.table_full);
                    end
                    mismatches++;
                end
            end
            results_seen++;
        end
    end

    task automatic queue_word(input logic kind, input logic [31:0] value);
        words_to_send.push_back('{kind, value});
        words_queued++;
    endtask

    // write both registers; core must be idle
    task automatic set_config(input logic [31:0] bg, input logic [3:0] mask);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= cpi_pkg::REG_BACKGROUND;
        cfg_wdata <= bg;
        bg_shadow  = bg;
        @(posedge aclk);
        cfg_index <= cpi_pkg::REG_CHAN_MASK;
        cfg_wdata <= {28'd0, mask};
        mask_shadow = mask;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for every queued word to be taken and answered, then let a
    // trailing clear word settle
    task automatic wait_drained();
        int spin;
        spin = 0;
        while ((words_to_send.size() != 0 || s_tvalid || expected_results.size() != 0)
               && spin < DRAIN_LIMIT) begin
            @(posedge aclk);
            spin++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // random bytes in the disabled channels
    function automatic logic [31:0] vary_masked(input logic [31:0] v);
        logic [31:0] noise;
        noise = $urandom();
        for (int c = 0; c < 4; c++) begin
            if (!mask_shadow[c]) v[8*c +: 8] = noise[8*c +: 8];
        end
        return v;
    endfunction

    // one image from a small palette, with background and stray pixels and occasional clear words
    task automatic queue_image(input int n_pix, input int n_colors);
        logic [31:0] palette_pick[$];
        int          k;
        logic [31:0] v;
        if ($urandom_range(0, 4) != 0) queue_word(cpi_pkg::KIND_CLEAR, $urandom());
        repeat (n_colors) palette_pick.push_back($urandom());
        repeat (n_pix) begin
            k = $urandom_range(0, 99);
            if (k == 99) queue_word(cpi_pkg::KIND_CLEAR, $urandom());
            if (k < 12)
                v = vary_masked(bg_shadow);
            else if (k < 18)
                v = $urandom();
            else
                v = vary_masked(palette_pick[$urandom_range(0, n_colors - 1)]);
            queue_word(cpi_pkg::KIND_PIXEL, v);
        end
    endtask

    // more distinct colours than the table holds, then hits and misses
    task automatic queue_table_fill();
        logic [31:0] stored[$];
        logic [31:0] v;
        queue_word(cpi_pkg::KIND_CLEAR, 32'h0);
        for (int i = 0; i < cpi_pkg::TABLE_DEPTH + 14; i++) begin
            v = $urandom();
            v[15:0] = 16'(i + 1);
            if (i < cpi_pkg::TABLE_DEPTH) stored.push_back(v);
            queue_word(cpi_pkg::KIND_PIXEL, v);
        end
        repeat (16) begin
            if ($urandom_range(0, 1) != 0)
                v = stored[$urandom_range(0, cpi_pkg::TABLE_DEPTH - 1)];
            else
                v = {16'($urandom_range(1, 65535)), 16'hFFFF};
            queue_word(cpi_pkg::KIND_PIXEL, v);
        end
        queue_word(cpi_pkg::KIND_PIXEL, stored[cpi_pkg::TABLE_DEPTH - 1]);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h0);
    endtask

    // main sequence
    initial begin : stimulus_proc
        int phase;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset values, background 0 on all channels
        queue_word(cpi_pkg::KIND_PIXEL, 32'h0000_0000);
        queue_word(cpi_pkg::KIND_PIXEL, 32'hFFFF_FFFF);
        queue_word(cpi_pkg::KIND_PIXEL, 32'hFFFF_FFFF);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h0000_0001);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h8000_0000);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h0000_0001);
        queue_word(cpi_pkg::KIND_CLEAR, 32'hFFFF_FFFF);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h8000_0000);
        queue_word(cpi_pkg::KIND_CLEAR, 32'h0000_0000);
        queue_word(cpi_pkg::KIND_CLEAR, 32'h1234_5678);
        queue_word(cpi_pkg::KIND_PIXEL, 32'hA5A5_A5A5);
        wait_drained();

        // empty mask: everything is background
        set_config(32'hFFFF_FFFF, 4'h0);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h1234_5678);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h0000_0000);
        wait_drained();

        // channel 0 only
        set_config(32'h0000_00AB, 4'h1);
        queue_word(cpi_pkg::KIND_CLEAR, 32'h0);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h0000_00AB);
        queue_word(cpi_pkg::KIND_PIXEL, 32'hFFFF_FFAB);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h1234_56CD);
        queue_word(cpi_pkg::KIND_PIXEL, 32'hFFFF_FFCD);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h0000_00CE);
        wait_drained();

        // channel 3 only
        set_config(32'h7F00_0000, 4'h8);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h7FFF_FFFF);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h8000_0000);
        queue_word(cpi_pkg::KIND_PIXEL, 32'h8012_3456);
        wait_drained();

        // random phases
        phase = 0;
        while (words_queued < TOTAL_WORDS - LAST_WORDS) begin
            case (phase)
                0:       set_config(32'h0000_0000, 4'hF);
                1:       set_config(32'hFFFF_FFFF, 4'hF);
                2:       set_config($urandom(), 4'h0);
                4:       set_config(32'h0000_0000, 4'hF);
                default: set_config($urandom(), 4'($urandom_range(1, 15)));
            endcase
            if (phase == 4) begin
                queue_table_fill();
            end else begin
                repeat ($urandom_range(2, 4))
                    queue_image($urandom_range(8, 60),
                                ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                            : $urandom_range(1, 12));
            end
            // receiver holds off while the sender keeps offering words
            if (phase == 3) begin
                @(posedge aclk);
                long_hold_req <= 1'b1;
                @(posedge aclk);
                long_hold_req <= 1'b0;
            end
            wait_drained();
            phase++;
        end

        // closing stretch at full rate
        idling_on = 1'b0;
        set_config($urandom(), 4'hF);
        queue_image(LAST_WORDS, 8);
        wait_drained();

        mismatches += expected_results.size();
        if (mismatches == 0)
            $display("color_patch_indexer_core: match");
        else
            $display("color_patch_indexer_core: mismatch");
        $finish;
    end

    // watchdog
    initial begin : watchdog_proc
        #(TIMEOUT_NS);
        $display("timeout after %0d results", results_seen);
        $display("color_patch_indexer_core: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cpi_pkg.sv
hw/rtl/cpi_table_engine.sv
hw/rtl/color_patch_indexer_core.sv
sim/color_patch_indexer_core_tb.sv
